>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> hw/rtl/mlfq_pkg.sv
// Constants, types and helper functions for the multilevel feedback scheduler.
`default_nettype none

package mlfq_pkg;

  localparam int MAX_JOBS  = 16;
  localparam int LEVELS    = 3;
  localparam int TIME_BITS = 16;

  localparam int JOB_ID_W = 4;
  localparam int DUR_W    = 16;
  localparam int REM_W    = 16;

  localparam int ID_W  = $clog2(MAX_JOBS);
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  localparam logic [31:0] TIME_MAX32 = 32'((64'd1 << TIME_BITS) - 64'd1);

  typedef logic [ID_W-1:0]      idx_t;
  typedef logic [LVL_W-1:0]     lvl_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [JOB_ID_W-1:0]  job_id_t;
  typedef logic [DUR_W-1:0]     dur_t;
  typedef logic [REM_W-1:0]     rem_t;

  localparam lvl_t LAST_LVL = lvl_t'(LEVELS - 1);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef enum logic {
    ACT_ARRIVE = 1'b0,
    ACT_TICK   = 1'b1
  } action_t;

  // Queue block control: one push and one pop per cycle.
  typedef struct packed {
    logic push_en;
    lvl_t push_lvl;
    idx_t push_id;
    logic pop_en;
  } q_ctrl_t;

  typedef struct packed {
    logic nonempty;
    idx_t head_id;
  } q_stat_t;

  // Job table read addresses.
  typedef struct packed {
    idx_t arr_id;
    idx_t run_id;
  } job_addr_t;

  // Job table write controls.
  typedef struct packed {
    logic  arr_en;
    time_t arr_time;
    logic  disp_en;
    lvl_t  disp_lvl;
    logic  run_en;
    time_t run_time;
    logic  run_done;
  } job_wr_t;

  typedef struct packed {
    logic  arr_busy;
    lvl_t  run_lvl;
    time_t run_time;
  } job_stat_t;

  // Clamps a requested duration to the widest count the table can hold.
  function automatic time_t sat_time(dur_t d);
    logic [31:0] w;
    w = 32'(d);
    if (w > TIME_MAX32) begin
      w = TIME_MAX32;
    end
    return time_t'(w);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mlfq_ifs.sv
// Request and result channel interfaces of the scheduler.
`default_nettype none

interface mlfq_req_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [mlfq_pkg::JOB_ID_W-1:0] job_id;
  logic [mlfq_pkg::DUR_W-1:0]    duration;

  modport source (output valid, action, job_id, duration, input ready);
  modport sink   (input valid, action, job_id, duration, output ready);
endinterface

interface mlfq_res_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic                          ran_valid;
  logic [mlfq_pkg::JOB_ID_W-1:0] ran_job;
  logic [mlfq_pkg::REM_W-1:0]    remaining;
  logic                          job_finished;

  modport source (output valid, status, ran_valid, ran_job, remaining, job_finished,
                  input ready);
  modport sink   (input valid, status, ran_valid, ran_job, remaining, job_finished,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mlfq_queues.sv
// Ring buffers for the priority levels, with the highest-priority head encoder.
`default_nettype none

module mlfq_queues (
  input  logic              clk,
  input  logic              rst,
  input  mlfq_pkg::q_ctrl_t ctrl,
  output mlfq_pkg::q_stat_t stat
);

  localparam int SUM_W = mlfq_pkg::CNT_W + 1;

  mlfq_pkg::idx_t fifo_mem [mlfq_pkg::LEVELS][mlfq_pkg::MAX_JOBS];
  mlfq_pkg::idx_t head     [mlfq_pkg::LEVELS];
  mlfq_pkg::cnt_t count    [mlfq_pkg::LEVELS];

  mlfq_pkg::idx_t head_val [mlfq_pkg::LEVELS];
  mlfq_pkg::lvl_t pop_lvl;
  mlfq_pkg::idx_t pop_next;
  logic           found;
  logic           push_ok;
  logic           pop_ok;
  logic [SUM_W-1:0] slot_sum;
  mlfq_pkg::idx_t slot;

  // Scan from the highest level down to level 0 so that level 0 wins.
  always_comb begin
    found   = 1'b0;
    pop_lvl = '0;
    for (int l = mlfq_pkg::LEVELS - 1; l >= 0; l--) begin
      if (count[l] != '0) begin
        found   = 1'b1;
        pop_lvl = mlfq_pkg::lvl_t'(l);
      end
    end
  end

  assign stat.nonempty = found;
  assign stat.head_id  = head_val[pop_lvl];

  assign push_ok = ctrl.push_en &&
                   (count[ctrl.push_lvl] < mlfq_pkg::cnt_t'(mlfq_pkg::MAX_JOBS));
  assign pop_ok  = ctrl.pop_en && found;

  assign pop_next = (head[pop_lvl] == mlfq_pkg::idx_t'(mlfq_pkg::MAX_JOBS - 1)) ? '0
                                                       : head[pop_lvl] + mlfq_pkg::idx_t'(1);

  // Tail slot is head plus count, wrapped once around the ring.
  always_comb begin
    slot_sum = SUM_W'(head[ctrl.push_lvl]) + SUM_W'(count[ctrl.push_lvl]);
    if (slot_sum >= SUM_W'(mlfq_pkg::MAX_JOBS)) begin
      slot_sum = slot_sum - SUM_W'(mlfq_pkg::MAX_JOBS);
    end
    slot = mlfq_pkg::idx_t'(slot_sum);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      fifo_mem[ctrl.push_lvl][slot] <= ctrl.push_id;
    end
  end

  // Each level keeps a registered copy of its head entry. A pop reloads it from the
  // next slot, and a request pushed into a level that is, or is about to be, empty
  // lands there directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
        head_val[l] <= '0;
      end
    end else begin
      for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
        if (pop_ok && (pop_lvl == mlfq_pkg::lvl_t'(l)) &&
            (count[l] != mlfq_pkg::cnt_t'(1))) begin
          head_val[l] <= fifo_mem[pop_lvl][pop_next];
        end else if (push_ok && (ctrl.push_lvl == mlfq_pkg::lvl_t'(l)) &&
                     ((count[l] == '0) || (pop_ok && (pop_lvl == mlfq_pkg::lvl_t'(l))))) begin
          head_val[l] <= ctrl.push_id;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
        head[l]  <= '0;
        count[l] <= '0;
      end
    end else begin
      for (int l = 0; l < mlfq_pkg::LEVELS; l++) begin
        if (pop_ok && (pop_lvl == mlfq_pkg::lvl_t'(l))) begin
          if (head[l] == mlfq_pkg::idx_t'(mlfq_pkg::MAX_JOBS - 1)) begin
            head[l] <= '0;
          end else begin
            head[l] <= head[l] + mlfq_pkg::idx_t'(1);
          end
        end
        if (push_ok && (ctrl.push_lvl == mlfq_pkg::lvl_t'(l)) &&
            !(pop_ok && (pop_lvl == mlfq_pkg::lvl_t'(l)))) begin
          count[l] <= count[l] + mlfq_pkg::cnt_t'(1);
        end else if (pop_ok && (pop_lvl == mlfq_pkg::lvl_t'(l)) &&
                     !(push_ok && (ctrl.push_lvl == mlfq_pkg::lvl_t'(l)))) begin
          count[l] <= count[l] - mlfq_pkg::cnt_t'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mlfq_jobs.sv
// Per-job table: remaining time, return level and busy flag.
`default_nettype none

module mlfq_jobs (
  input  logic                clk,
  input  logic                rst,
  input  mlfq_pkg::job_addr_t addr,
  input  mlfq_pkg::job_wr_t   wr,
  output mlfq_pkg::job_stat_t stat
);

  mlfq_pkg::time_t                time_left [mlfq_pkg::MAX_JOBS];
  mlfq_pkg::lvl_t                 ret_lvl   [mlfq_pkg::MAX_JOBS];
  logic [mlfq_pkg::MAX_JOBS-1:0]  busy;

  assign stat.arr_busy = busy[addr.arr_id];
  assign stat.run_lvl  = ret_lvl[addr.run_id];
  assign stat.run_time = time_left[addr.run_id];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      for (int j = 0; j < mlfq_pkg::MAX_JOBS; j++) begin
        time_left[j] <= '0;
        ret_lvl[j]   <= '0;
      end
    end else begin
      if (wr.arr_en) begin
        time_left[addr.arr_id] <= wr.arr_time;
        ret_lvl[addr.arr_id]   <= '0;
        busy[addr.arr_id]      <= 1'b1;
      end
      if (wr.disp_en) begin
        ret_lvl[addr.run_id] <= wr.disp_lvl;
      end
      if (wr.run_en) begin
        time_left[addr.run_id] <= wr.run_time;
        if (wr.run_done) begin
          busy[addr.run_id] <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/multilevel_feedback_scheduler_top.sv
// Top level of the multilevel feedback scheduler: input register, dispatch logic, result register.
//
//   Channel | Direction | Payload                                         | Handshake
//   req     | in        | action, job_id, duration                        | valid/ready
//   res     | out       | status, ran_valid, ran_job, remaining, job_finished | valid/ready
//
// Each request is held in the input register; the dispatch decision, the
// queue push and pop and the job table update all happen as it moves into the result
// register, so one request per cycle is sustained while results are taken.
// Synchronous reset clears all queues, the job table and both handshake stages.
// A stalled result holds the input register; a new request is still taken whenever
// the input register is empty or moving on.
`default_nettype none
`include "assert_macros.svh"

module multilevel_feedback_scheduler_top (
  input  logic           clk,
  input  logic           rst,
  mlfq_req_if.sink       req,
  mlfq_res_if.source     res
);

  // Input register
  logic                s1_valid;
  mlfq_pkg::action_t   s1_action;
  mlfq_pkg::job_id_t   s1_id;
  mlfq_pkg::dur_t      s1_dur;

  // Result register
  logic                res_valid;
  mlfq_pkg::status_t   res_status;
  logic                res_ran_valid;
  mlfq_pkg::job_id_t   res_ran_job;
  mlfq_pkg::rem_t      res_remaining;
  logic                res_finished;

  // Running job
  logic                cur_valid;
  mlfq_pkg::idx_t      cur_job;
  mlfq_pkg::lvl_t      cur_lvl;

  logic                adv;
  logic                fire;
  logic                is_tick;
  logic                id_oob;
  mlfq_pkg::status_t   status;
  logic                arr_ok;
  logic                dispatch;
  logic                keep;
  logic                run;
  mlfq_pkg::idx_t      run_id;
  mlfq_pkg::time_t     t_next;
  logic                done;
  mlfq_pkg::lvl_t      next_lvl;

  mlfq_pkg::q_ctrl_t   qc;
  mlfq_pkg::q_stat_t   qs;
  mlfq_pkg::job_addr_t ja;
  mlfq_pkg::job_wr_t   jw;
  mlfq_pkg::job_stat_t js;

  assign adv       = !res_valid || res.ready;
  assign fire      = s1_valid && adv;
  assign req.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_action <= mlfq_pkg::action_t'(req.action);
      s1_id     <= req.job_id;
      s1_dur    <= req.duration;
    end
  end

  assign is_tick = (s1_action == mlfq_pkg::ACT_TICK);
  assign id_oob  = (32'(s1_id) >= mlfq_pkg::MAX_JOBS);

  always_comb begin
    if (is_tick) begin
      status = mlfq_pkg::ST_OK;
    end else if (id_oob || js.arr_busy) begin
      status = mlfq_pkg::ST_BUSY;
    end else if (s1_dur == '0) begin
      status = mlfq_pkg::ST_ZERO;
    end else begin
      status = mlfq_pkg::ST_OK;
    end
  end

  assign arr_ok   = !is_tick && (status == mlfq_pkg::ST_OK);
  assign dispatch = is_tick && qs.nonempty;
  // With every level empty the running job keeps the processor.
  assign keep     = is_tick && !qs.nonempty && cur_valid;
  assign run      = dispatch || keep;
  assign run_id   = dispatch ? qs.head_id : cur_job;

  assign t_next   = (js.run_time != '0) ? js.run_time - mlfq_pkg::time_t'(1) : js.run_time;
  assign done     = (t_next == '0);
  assign next_lvl = (js.run_lvl == mlfq_pkg::LAST_LVL) ? mlfq_pkg::LAST_LVL
                                                       : js.run_lvl + mlfq_pkg::lvl_t'(1);

  // A preempted job is pushed back into its level in the same cycle as the pop; an arrival is pushed into level 0.
  always_comb begin
    qc.push_en  = fire && (arr_ok || (dispatch && cur_valid));
    qc.push_lvl = is_tick ? cur_lvl : '0;
    qc.push_id  = is_tick ? cur_job : mlfq_pkg::idx_t'(s1_id);
    qc.pop_en   = fire && dispatch;
  end

  always_comb begin
    ja.arr_id   = mlfq_pkg::idx_t'(s1_id);
    ja.run_id   = run_id;
    jw.arr_en   = fire && arr_ok;
    jw.arr_time = mlfq_pkg::sat_time(s1_dur);
    jw.disp_en  = fire && dispatch;
    jw.disp_lvl = next_lvl;
    jw.run_en   = fire && run;
    jw.run_time = t_next;
    jw.run_done = done;
  end

  mlfq_queues u_queues (
    .clk  (clk),
    .rst  (rst),
    .ctrl (qc),
    .stat (qs)
  );

  mlfq_jobs u_jobs (
    .clk  (clk),
    .rst  (rst),
    .addr (ja),
    .wr   (jw),
    .stat (js)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_job   <= '0;
      cur_lvl   <= '0;
    end else if (fire && dispatch) begin
      cur_job   <= qs.head_id;
      cur_lvl   <= next_lvl;
      cur_valid <= !done;
    end else if (fire && keep && done) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_status    <= status;
      res_ran_valid <= run;
      res_ran_job   <= run ? mlfq_pkg::job_id_t'(run_id) : '0;
      res_remaining <= run ? mlfq_pkg::rem_t'(t_next) : '0;
      res_finished  <= run && done;
    end
  end

  assign res.valid        = res_valid;
  assign res.status       = res_status;
  assign res.ran_valid    = res_ran_valid;
  assign res.ran_job      = res_ran_job;
  assign res.remaining    = res_remaining;
  assign res.job_finished = res_finished;

  `ASSERT_NEXT(a_arrive_no_slice, fire && !is_tick, res_valid && !res_ran_valid)
  `ASSERT_NEXT(a_idle_tick, fire && is_tick && !qs.nonempty && !cur_valid, res_valid && !res_ran_valid && (res_status == mlfq_pkg::ST_OK))
  `ASSERT_NEXT(a_dispatch_runs_head, fire && dispatch, res_ran_valid && (res_ran_job == mlfq_pkg::job_id_t'($past(qs.head_id))))
  `ASSERT_IMPLIES(a_keep_needs_job, fire && keep, cur_valid && (js.run_time != '0))

endmodule

`default_nettype wire
